/* src/twpd_pkg.sv */
// Package for the two-wheel PD speed and position controller.
// Holds the operation, mode and action codes, the per-wheel state word and fixed constants.
// No dependencies.
package twpd_pkg;

  localparam int unsigned NUM_WHEELS  = 2;
  localparam int unsigned WHEEL_W     = 1;
  localparam int unsigned PI_Q16      = 205887;  // pi with 16 fraction bits
  // The move offset is mag * K / (D * pi), taken as (mag * RECIP) >> RECIP_SHIFT.
  localparam int unsigned RECIP_SHIFT = 44;
  localparam int unsigned RECIP_HALF  = 30;      // reciprocal is split in two halves this wide
  localparam int unsigned RECIP_W     = 2 * RECIP_HALF;
  localparam int unsigned FRAC_BITS   = 16;      // fraction bits of the gain products

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SPEED = 2'd1,
    OP_MOVE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_SPEED = 2'd1,
    MODE_POS   = 2'd2
  } mode_e;

  // What the back half of the pipeline does with a transaction.
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_PD   = 2'd1,
    ACT_STOP = 2'd2,
    ACT_LOAD = 2'd3
  } act_e;

  typedef enum logic {
    REG_GAIN_PROP  = 1'b0,
    REG_GAIN_DERIV = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [39:0] ref_pos;
    logic signed [39:0] prev_err;
    logic signed [31:0] target;
    mode_e              mode;
    logic signed [15:0] speed;
  } ctl_state_t;

endpackage

/* src/twpd_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// A read at the address being written returns the old contents.
// No dependencies.
module twpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/two_wheel_pd_speed_position_control.sv */
// Two-wheel incremental PD controller with speed and position modes.
// A result is offered from the output register, which follows the stage 1, 2 and 3 registers.
// Throughput: one transaction per cycle while the output does not stall; per-wheel state sits
// in a RAM read, updated and written back once per cycle, with same-entry forwarding, and the
// drive RAM likewise. Reset clears the valid bits of both RAMs, so every wheel reads as zero
// and off; no clearing pass is needed. Gains reset to zero. Depends on twpd_pkg and twpd_ram.
module two_wheel_pd_speed_position_control
  import twpd_pkg::*;
#(
  parameter int unsigned COUNTS_PER_REV    = 48,
  parameter int unsigned WHEEL_DIAMETER_MM = 69
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // encoder_count[31:0], speed_counts[47:32],
                                     // distance_mm[63:48], start_power[79:64]
  input  logic [2:0]  s_axis_tuser,  // operation[1:0], wheel_sel[2]
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // drive_power[15:0]
  output logic [1:0]  m_axis_tuser,  // wheel_out[0], still_active[1]
  // Configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned STATE_W = $bits(ctl_state_t);
  localparam logic [95:0] DEN = 96'(WHEEL_DIAMETER_MM) * 96'(PI_Q16);
  localparam logic [95:0] RECIP =
      ((96'(COUNTS_PER_REV) << (RECIP_SHIFT + FRAC_BITS)) + DEN - 96'd1) / DEN;
  localparam logic [RECIP_HALF-1:0] RECIP_LO = RECIP[RECIP_HALF-1:0];
  localparam logic [RECIP_HALF-1:0] RECIP_HI = RECIP[RECIP_W-1:RECIP_HALF];
  localparam int unsigned PROD_W = 16 + RECIP_HALF;

  // Configuration registers
  logic [15:0] gain_prop_q, gain_deriv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q  <= '0;
      gain_deriv_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_GAIN_PROP:  gain_prop_q  <= cfg_data_i;
        REG_GAIN_DERIV: gain_deriv_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  logic take1, take2, take3, take_o, in_acc;
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;

  assign take_o        = !out_v_q || m_axis_tready;
  assign take3         = !s3_v_q || take_o;
  assign take2         = !s2_v_q || take3;
  assign take1         = !s1_v_q || take2;
  assign s_axis_tready = take1;
  assign in_acc        = s_axis_tvalid && take1;

  // Input unpacking and the offset products for a position move
  logic signed [15:0]  in_dist;
  logic [15:0]         in_mag;
  logic [PROD_W-1:0]   in_ph, in_pl;

  assign in_dist = s_axis_tdata[63:48];
  assign in_mag  = in_dist[15] ? 16'(-in_dist) : in_dist;
  assign in_ph   = PROD_W'(in_mag) * PROD_W'(RECIP_HI);
  assign in_pl   = PROD_W'(in_mag) * PROD_W'(RECIP_LO);

  // Stage 1 registers
  op_e                s1_op_q;
  logic [WHEEL_W-1:0] s1_wheel_q;
  logic signed [31:0] s1_enc_q;
  logic signed [15:0] s1_spd_q, s1_pwr_q;
  logic               s1_dneg_q;
  logic [PROD_W-1:0]  s1_ph_q, s1_pl_q;

  // Stage 2 registers
  act_e               s2_act_q;
  logic [WHEEL_W-1:0] s2_wheel_q;
  logic signed [39:0] s2_err_q, s2_perr_q;
  logic signed [15:0] s2_pwr_q;

  // Stage 3 registers
  act_e               s3_act_q;
  logic [WHEEL_W-1:0] s3_wheel_q;
  logic signed [56:0] s3_pp_q;
  logic signed [57:0] s3_pd_q;
  logic signed [15:0] s3_pwr_q;

  // Output register
  logic [WHEEL_W-1:0] out_wheel_q;
  logic signed [15:0] out_drive_q;
  logic               out_active_q;

  // Control-state RAM, read at acceptance and written back from stage 1
  logic [STATE_W-1:0]    ram_a_rdata;
  logic [WHEEL_W-1:0]    ram_a_raddr;
  logic                  ram_a_we;
  logic [NUM_WHEELS-1:0] a_vld_q;
  logic                  a_rvld_q, a_fwd_q;
  ctl_state_t            a_fwd_data_q;
  ctl_state_t            st, st_n;

  assign ram_a_raddr = take1 ? s_axis_tuser[2] : s1_wheel_q;
  assign ram_a_we    = s1_v_q && take2;

  twpd_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NUM_WHEELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_a_we),
    .waddr_i (s1_wheel_q),
    .wdata_i (st_n),
    .raddr_i (ram_a_raddr),
    .rdata_o (ram_a_rdata)
  );

  // Drive RAM, read as a transaction enters stage 3 and written from stage 3
  logic [15:0]           ram_b_rdata;
  logic [WHEEL_W-1:0]    ram_b_raddr;
  logic                  ram_b_we;
  logic signed [15:0]    ram_b_wdata;
  logic [NUM_WHEELS-1:0] b_vld_q;
  logic                  b_rvld_q, b_fwd_q;
  logic signed [15:0]    b_fwd_data_q;
  logic signed [15:0]    drv_old, drv_n;

  assign ram_b_raddr = take3 ? s2_wheel_q : s3_wheel_q;

  twpd_ram #(
    .WIDTH (16),
    .DEPTH (NUM_WHEELS)
  ) u_drive_ram (
    .clk_i   (clk_i),
    .we_i    (ram_b_we),
    .waddr_i (s3_wheel_q),
    .wdata_i (ram_b_wdata),
    .raddr_i (ram_b_raddr),
    .rdata_o (ram_b_rdata)
  );

  // Valid bits and forwarding of a write that lands in the cycle of the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q  <= '0;
      b_vld_q  <= '0;
      a_rvld_q <= 1'b0;
      b_rvld_q <= 1'b0;
      a_fwd_q  <= 1'b0;
      b_fwd_q  <= 1'b0;
    end else begin
      a_rvld_q <= a_vld_q[ram_a_raddr];
      b_rvld_q <= b_vld_q[ram_b_raddr];
      a_fwd_q  <= ram_a_we && (s1_wheel_q == ram_a_raddr);
      b_fwd_q  <= ram_b_we && (s3_wheel_q == ram_b_raddr);
      if (ram_a_we) begin
        a_vld_q[s1_wheel_q] <= 1'b1;
      end
      if (ram_b_we) begin
        b_vld_q[s3_wheel_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_fwd_data_q <= st_n;
    b_fwd_data_q <= ram_b_wdata;
  end

  always_comb begin
    if (a_fwd_q) begin
      st = a_fwd_data_q;
    end else if (a_rvld_q) begin
      st = ctl_state_t'(ram_a_rdata);
    end else begin
      st = '0;
    end
  end

  // Stage 1: reference advance, error, target, mode update
  logic signed [39:0] ref_n, enc_sh, err_n;
  logic signed [40:0] diff;
  logic [75:0]        qsum;
  logic [31:0]        q_off;
  logic signed [33:0] off, tsum;
  logic signed [31:0] tgt_n;
  act_e               act_n;

  assign ref_n  = st.ref_pos + 40'(st.speed);
  assign enc_sh = {s1_enc_q, 8'd0};
  assign diff   = 41'(ref_n) - 41'(enc_sh);
  assign err_n  = (diff[40] != diff[39]) ? {diff[40], {39{~diff[40]}}} : diff[39:0];

  assign qsum  = {s1_ph_q, {RECIP_HALF{1'b0}}} + 76'(s1_pl_q);
  assign q_off = qsum[75:RECIP_SHIFT];
  assign off   = s1_dneg_q ? -$signed({2'b00, q_off}) : $signed({2'b00, q_off});
  assign tsum  = 34'(s1_enc_q) + off;

  always_comb begin
    if (!tsum[33] && (tsum[32:31] != 2'b00)) begin
      tgt_n = 32'sh7FFF_FFFF;
    end else if (tsum[33] && (tsum[32:31] != 2'b11)) begin
      tgt_n = -32'sh8000_0000;
    end else begin
      tgt_n = tsum[31:0];
    end
  end

  always_comb begin
    st_n  = st;
    act_n = ACT_NONE;
    unique case (s1_op_q)
      OP_TICK: begin
        unique case (st.mode)
          MODE_SPEED: begin
            act_n         = ACT_PD;
            st_n.ref_pos  = ref_n;
            st_n.prev_err = err_n;
          end
          MODE_POS: begin
            if (st.target > s1_enc_q) begin
              act_n         = ACT_PD;
              st_n.ref_pos  = ref_n;
              st_n.prev_err = err_n;
            end else begin
              act_n     = ACT_STOP;
              st_n.mode = MODE_OFF;
            end
          end
          default: ;
        endcase
      end
      OP_SPEED: begin
        st_n.speed = s1_spd_q;
        st_n.mode  = MODE_SPEED;
      end
      OP_MOVE: begin
        act_n       = ACT_LOAD;
        st_n.target = tgt_n;
        st_n.mode   = MODE_POS;
      end
      default: ;
    endcase
  end

  // Stage 2: error change and the two gain products
  logic signed [40:0] delta;
  logic signed [56:0] pp_n;
  logic signed [57:0] pd_n;

  assign delta = 41'(s2_err_q) - 41'(s2_perr_q);
  assign pp_n  = 57'(s2_err_q) * 57'($signed({1'b0, gain_prop_q}));
  assign pd_n  = 58'(delta) * 58'($signed({1'b0, gain_deriv_q}));

  // Stage 3: floor of the drive change, saturating accumulate, write back
  logic signed [58:0] psum;
  logic signed [42:0] change;
  logic signed [43:0] acc;
  logic               res_v;

  assign drv_old = b_fwd_q ? b_fwd_data_q : (b_rvld_q ? $signed(ram_b_rdata) : 16'sd0);
  assign psum    = 59'(s3_pp_q) + 59'(s3_pd_q);
  assign change  = psum[58:FRAC_BITS];
  assign acc     = 44'(drv_old) + 44'(change);

  always_comb begin
    if (!acc[43] && (acc[42:15] != '0)) begin
      drv_n = 16'sh7FFF;
    end else if (acc[43] && (acc[42:15] != '1)) begin
      drv_n = -16'sh8000;
    end else begin
      drv_n = acc[15:0];
    end
  end

  assign ram_b_we    = s3_v_q && take_o && ((s3_act_q == ACT_PD) || (s3_act_q == ACT_LOAD));
  assign ram_b_wdata = (s3_act_q == ACT_PD) ? drv_n : s3_pwr_q;
  assign res_v       = s3_v_q && ((s3_act_q == ACT_PD) || (s3_act_q == ACT_STOP));

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (take1) begin
        s1_v_q <= s_axis_tvalid;
      end
      if (take2) begin
        s2_v_q <= s1_v_q;
      end
      if (take3) begin
        s3_v_q <= s2_v_q;
      end
      if (take_o) begin
        out_v_q <= res_v;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q    <= op_e'(s_axis_tuser[1:0]);
      s1_wheel_q <= s_axis_tuser[2];
      s1_enc_q   <= s_axis_tdata[31:0];
      s1_spd_q   <= s_axis_tdata[47:32];
      s1_pwr_q   <= s_axis_tdata[79:64];
      s1_dneg_q  <= in_dist[15];
      s1_ph_q    <= in_ph;
      s1_pl_q    <= in_pl;
    end
    if (take2) begin
      s2_act_q   <= act_n;
      s2_wheel_q <= s1_wheel_q;
      s2_err_q   <= err_n;
      s2_perr_q  <= st.prev_err;
      s2_pwr_q   <= s1_pwr_q;
    end
    if (take3) begin
      s3_act_q   <= s2_act_q;
      s3_wheel_q <= s2_wheel_q;
      s3_pp_q    <= pp_n;
      s3_pd_q    <= pd_n;
      s3_pwr_q   <= s2_pwr_q;
    end
    if (take_o && res_v) begin
      out_wheel_q  <= s3_wheel_q;
      out_drive_q  <= (s3_act_q == ACT_PD) ? drv_n : 16'sd0;
      out_active_q <= (s3_act_q == ACT_PD);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_drive_q;
  assign m_axis_tuser  = {out_active_q, out_wheel_q};

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for two_wheel_pd_speed_position_control.
// Holds a scoreboard class that predicts the per-wheel PD drive, plus stream drivers and
// a result sink with random stalls. Depends on twpd_pkg and the controller RTL.
module tb_top;
  import twpd_pkg::*;

  localparam longint      COUNTS_REV  = 48;
  localparam longint      WHEEL_DIA   = 69;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned MAX_GAP     = 17;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned HOLD_AT     = 150;
  localparam int unsigned SETTLE      = 10;
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int          ENC_MAX     = 32'sh7FFF_FFFF;
  localparam int          ENC_MIN     = 32'sh8000_0000;
  localparam longint      ERR_MAX     = (longint'(1) <<< 39) - 1;
  localparam longint      ERR_MIN     = -ERR_MAX - 1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;  // encoder_count, speed_counts, distance_mm, start_power
  logic [2:0]  s_axis_tuser = '0;  // operation[1:0], wheel_sel[2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // drive_power
  logic [1:0]  m_axis_tuser;       // wheel_out[0], still_active[1]
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  typedef struct packed {
    logic        wheel;
    logic [15:0] drive;
    logic        active;
  } drive_result_t;

  class drive_scoreboard;
    logic [15:0]   gain_p;
    logic [15:0]   gain_d;
    longint        ref_pos [2];
    longint        prev_err [2];
    longint        target [2];
    longint        acc_drive [2];
    longint        speed [2];
    mode_e         mode [2];
    drive_result_t expected_q [$];
    int unsigned   errors;

    function new();
      gain_p = '0;
      gain_d = '0;
      errors = 0;
      for (int i = 0; i < 2; i++) begin
        ref_pos[i]   = 0;
        prev_err[i]  = 0;
        target[i]    = 0;
        acc_drive[i] = 0;
        speed[i]     = 0;
        mode[i]      = MODE_OFF;
      end
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void set_gain(reg_idx_e idx, logic [15:0] v);
      if (idx == REG_GAIN_PROP) gain_p = v;
      else gain_d = v;
    endfunction

    // One PD update; the Q.16 sum is floored by the arithmetic shift.
    function logic [15:0] pd_step(bit w, longint enc);
      longint r;
      longint e;
      longint de;
      longint chg;
      r   = ((ref_pos[w] + speed[w]) <<< 24) >>> 24;
      e   = clamp(r - enc * 256, ERR_MIN, ERR_MAX);
      de  = e - prev_err[w];
      chg = (e * longint'(gain_p) + de * longint'(gain_d)) >>> 16;
      ref_pos[w]   = r;
      prev_err[w]  = e;
      acc_drive[w] = clamp(acc_drive[w] + chg, -32768, 32767);
      return acc_drive[w][15:0];
    endfunction

    function void note_input(logic [1:0] op, bit w, int enc, shortint spd, shortint dist_mm,
                             shortint pwr);
      drive_result_t res;
      longint        off;
      if (op == OP_SPEED) begin
        speed[w] = spd;
        mode[w]  = MODE_SPEED;
      end else if (op == OP_MOVE) begin
        off = (dist_mm < 0) ? -longint'(dist_mm) : longint'(dist_mm);
        off = (off * COUNTS_REV * 65536) / (WHEEL_DIA * longint'(PI_Q16));
        if (dist_mm < 0) off = -off;
        target[w]    = clamp(longint'(enc) + off, longint'(ENC_MIN), longint'(ENC_MAX));
        acc_drive[w] = pwr;
        mode[w]      = MODE_POS;
      end else if (op == OP_TICK) begin
        if (mode[w] == MODE_SPEED || (mode[w] == MODE_POS && target[w] > longint'(enc))) begin
          res.wheel  = w;
          res.drive  = pd_step(w, enc);
          res.active = 1'b1;
          expected_q.push_back(res);
        end else if (mode[w] == MODE_POS) begin
          // Target reached: zero drive, the wheel drops out of control.
          mode[w] = MODE_OFF;
          res     = '{wheel: w, drive: 16'd0, active: 1'b0};
          expected_q.push_back(res);
        end
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 200) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_result(logic wheel, logic [15:0] drive, logic active);
      drive_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result wheel %0d drive %0d active %0d",
                                  wheel, $signed(drive), active));
        return;
      end
      want = expected_q.pop_front();
      if (wheel !== want.wheel)
        report_mismatch($sformatf("wheel_out %0d, want %0d", wheel, want.wheel));
      if (drive !== want.drive)
        report_mismatch($sformatf("wheel %0d drive_power %0d, want %0d", want.wheel,
                                  $signed(drive), $signed(want.drive)));
      if (active !== want.active)
        report_mismatch($sformatf("wheel %0d still_active %0d, want %0d", want.wheel,
                                  active, want.active));
    endtask
  endclass

  drive_scoreboard sb = new();
  int              enc_track [2] = '{0, 0};
  shortint         cmd_speed [2] = '{0, 0};
  int unsigned     send_burst = 0;

  two_wheel_pd_speed_position_control uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser[0], m_axis_tdata, m_axis_tuser[1]);
  end

  task automatic write_gain(reg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_gain(idx, val);
  endtask

  // Offers one item after a random gap and returns at the edge that accepts it.
  task automatic send_item(logic [1:0] op, bit w, int enc, shortint spd, shortint dist_mm,
                           shortint pwr);
    int unsigned gap;
    if (send_burst > 0) begin
      gap = 0;
      send_burst--;
    end else if ($urandom_range(0, 7) == 0) begin
      gap = 0;
      send_burst = $urandom_range(20, 60);
    end else begin
      gap = $urandom_range(0, MAX_GAP);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pwr, dist_mm, spd, enc};
    s_axis_tuser  <= {w, op};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_input(op, w, enc, spd, dist_mm, pwr);
  endtask

  // Some items never produce a result, so the pipeline also gets quiet cycles after the queue empties.
  task automatic drain();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Mostly plausible traffic: the encoder follows the commanded speed so that moves finish.
  task automatic run_phase(logic [15:0] gp, logic [15:0] gd, int unsigned n_items);
    int unsigned done_cnt;
    int unsigned pick;
    bit          w;
    int          enc;
    shortint     spd;
    shortint     dist_mm;
    shortint     pwr;
    logic [1:0]  op;
    write_gain(REG_GAIN_PROP, gp);
    write_gain(REG_GAIN_DERIV, gd);
    done_cnt = 0;
    while (done_cnt < n_items) begin
      w       = 1'($urandom_range(0, 1));
      pick    = $urandom_range(0, 99);
      spd     = shortint'($urandom);
      dist_mm = shortint'($urandom);
      pwr     = shortint'($urandom);
      enc_track[w] += (cmd_speed[w] >>> 8) + int'($urandom_range(0, 6)) - 1;
      enc = ($urandom_range(0, 19) == 0) ? int'($urandom) : enc_track[w];
      if (pick < 3) begin
        op = OP_UNUSED;
      end else if (pick < 13) begin
        op = OP_SPEED;
        if ($urandom_range(0, 6) != 0) spd = shortint'(int'($urandom_range(0, 2816)) - 256);
        cmd_speed[w] = spd;
      end else if (pick < 21) begin
        op = OP_MOVE;
        if ($urandom_range(0, 4) != 0) dist_mm = shortint'(int'($urandom_range(0, 440)) - 40);
      end else begin
        op = OP_TICK;
      end
      send_item(op, w, enc, spd, dist_mm, pwr);
      if (op != OP_UNUSED) done_cnt++;
    end
    drain();
  endtask

  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    int unsigned quiet_left;
    taken      = 0;
    quiet_left = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      // One long hold-off lets the input side back up and stall.
      if (taken == HOLD_AT) begin
        stall = LONG_HOLD;
      end else if (quiet_left > 0) begin
        stall = 0;
        quiet_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        stall = 0;
        quiet_left = $urandom_range(20, 60);
      end else begin
        stall = $urandom_range(0, MAX_GAP);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      taken++;
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_gain(REG_GAIN_PROP, 16'h0180);
    write_gain(REG_GAIN_DERIV, 16'h0040);
    send_item(OP_TICK, 1'b0, 0, 0, 0, 0);              // wheel is off: no result
    send_item(OP_UNUSED, 1'b1, -1, -1, -1, -1);         // unused operation is ignored
    send_item(OP_SPEED, 1'b0, 0, 32767, 0, 0);
    send_item(OP_TICK, 1'b0, 0, 0, 0, 0);
    send_item(OP_TICK, 1'b0, ENC_MIN, 0, 0, 0);        // error saturates high
    send_item(OP_TICK, 1'b0, ENC_MAX, 0, 0, 0);
    send_item(OP_SPEED, 1'b1, 0, -32768, 0, 0);
    send_item(OP_TICK, 1'b1, ENC_MAX, 0, 0, 0);        // error saturates low
    send_item(OP_MOVE, 1'b1, 0, 0, 32767, 32767);
    send_item(OP_TICK, 1'b1, 100, 0, 0, 0);
    send_item(OP_TICK, 1'b1, 8000, 0, 0, 0);           // target passed: stop
    send_item(OP_TICK, 1'b1, 0, 0, 0, 0);
    send_item(OP_MOVE, 1'b0, ENC_MAX, 0, 32767, -32768); // target clips at the top
    send_item(OP_TICK, 1'b0, ENC_MAX, 0, 0, 0);
    send_item(OP_MOVE, 1'b0, ENC_MIN, 0, -32768, 0);   // target clips at the bottom
    send_item(OP_TICK, 1'b0, ENC_MIN, 0, 0, 0);
    send_item(OP_MOVE, 1'b1, 0, 0, 0, 1000);
    send_item(OP_TICK, 1'b1, -1, 0, 0, 0);
    send_item(OP_TICK, 1'b1, 0, 0, 0, 0);              // target equals encoder: stop
    send_item(OP_SPEED, 1'b1, 0, 0, 0, 0);
    send_item(OP_TICK, 1'b1, 0, 0, 0, 0);
    send_item(OP_SPEED, 1'b0, 0, -1, 0, 0);
    send_item(OP_TICK, 1'b0, -5, 0, 0, 0);
    drain();

    run_phase(16'hFFFF, 16'hFFFF, 140);
    run_phase(16'h0000, 16'h0000, 140);
    run_phase(16'h0100, 16'h0000, 140);
    run_phase(16'h0000, 16'h0100, 140);
    run_phase(16'($urandom_range(1, 1024)), 16'($urandom_range(1, 1024)), 140);

    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
